// ----- design/assert_macros.svh -----
// Assertion macros used by the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check that is switched off while the reset is held.
`define SFDF_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent check that also holds while the reset is held.
`define SFDF_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- design/sfdf_pkg.sv -----
// Types and constants of the sampled flow duplicate filter.
package sfdf_pkg;

    localparam int HASH_W      = 64;
    localparam int THR_W       = 31;
    localparam int HCNT_W      = 4;
    localparam int WCNT_W      = 12;
    localparam int IDX_IN_W    = 16;
    localparam int MOD_STEP    = 4;
    localparam int MAX_POS     = 8;
    localparam int POS_W       = 6;
    localparam int STATUS_BIT  = 32;
    localparam int SAMPLE_LSB  = 33;
    localparam int CFG_IDX_W   = 2;
    localparam int WORDS_DEF   = 2048;

    localparam logic [HASH_W-1:0] WORD_RESET = 64'hAAAA_AAAA_AAAA_AAAA;

    localparam logic [THR_W-1:0]  THR_RESET  = 31'd429496730;
    localparam logic [HCNT_W-1:0] HCNT_RESET = 4'd4;
    localparam logic [WCNT_W-1:0] WCNT_RESET = 12'd1250;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HASH_COUNT       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WORD_COUNT       = 2'd2;

    typedef logic [WCNT_W-1:0] t_wcnt;

endpackage

// ----- design/sampled_flow_dedup_filter.sv -----
// Sampled flow duplicate filter: top level with filter memory and control.
//
// Input channel (i_in_valid / o_in_ready) carries the two 64-bit halves of a
// packet key hash. Output channel (o_out_valid / i_out_ready) carries one
// beat per input beat with the sampled, already_recorded and forward flags.
// The configuration port writes sample_threshold, hash_count and word_count
// with no wait; writes to an unused index are dropped.
//
// One item is processed at a time. A sampled item passes from acceptance
// through the radix-16 remainder unit that maps the word index onto
// word_count, a memory read step and a read-modify-write step to the load
// of the output register, and only then is the next item accepted. An
// item that is not sampled goes straight to the output register load.
//
// After reset the filter memory is swept to its initial pattern, one word
// per cycle, so no item is accepted until the sweep is over; register
// writes are taken during the sweep. When the receiver stalls, the result
// waits in the output register and the block holds the finished item until
// the output register frees up, then returns to accept the next beat.
module sampled_flow_dedup_filter #(
    parameter int WORDS = sfdf_pkg::WORDS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [sfdf_pkg::HASH_W-1:0]    i_hash_low,
    input  logic [sfdf_pkg::HASH_W-1:0]    i_hash_high,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic                           o_sampled,
    output logic                           o_already_recorded,
    output logic                           o_forward,
    input  logic                           i_cfg_we,
    input  logic [sfdf_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [sfdf_pkg::THR_W-1:0]     i_cfg_data
);
    import sfdf_pkg::*;

    `include "assert_macros.svh"

    localparam int IDX_W = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam logic [IDX_IN_W:0] WORDS_X = (IDX_IN_W + 1)'(WORDS);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_DIV   = 3'd2;
    localparam logic [2:0] ST_READ  = 3'd3;
    localparam logic [2:0] ST_MOD   = 3'd4;
    localparam logic [2:0] ST_PUSH  = 3'd5;

    logic [2:0]        r_state;
    logic [2:0]        n_state;
    logic [IDX_W-1:0]  r_clr_addr;

    logic [THR_W-1:0]  r_threshold;
    logic [HCNT_W-1:0] r_hash_count;
    t_wcnt             r_word_count;

    logic [HASH_W-1:0] r_hash_high;
    logic              r_status;
    logic [HCNT_W-1:0] r_npos;
    logic              r_res_sampled;
    logic              r_res_repeat;

    logic              r_out_valid;
    logic              r_out_sampled;
    logic              r_out_repeat;

    logic [HASH_W-1:0] r_filter_mem [WORDS];
    logic [HASH_W-1:0] r_rd_data;

    logic              in_fire;
    logic              sampled_now;
    logic [HCNT_W-1:0] npos_now;
    t_wcnt             eff_words;
    logic              mod_done;
    t_wcnt             mod_rem;
    logic [IDX_IN_W-1:0] rem_ext;
    logic [IDX_W-1:0]  word_idx;
    logic              out_free;

    logic [MAX_POS-1:0] mism;
    logic [MAX_POS-1:0] active;
    logic [HASH_W-1:0]  set_mask;
    logic [HASH_W-1:0]  new_word;
    logic               item_repeat;
    logic               seen;

    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    logic [HASH_W-1:0] mem_wdata;

    assign in_fire     = i_in_valid && o_in_ready;
    assign o_in_ready  = (r_state == ST_IDLE);
    assign sampled_now = i_hash_low[HASH_W-1:SAMPLE_LSB] < r_threshold;
    assign npos_now    = (r_hash_count > HCNT_W'(MAX_POS)) ? HCNT_W'(MAX_POS) : r_hash_count;
    assign out_free    = !r_out_valid || i_out_ready;

    // Word count of zero acts as one; counts above the memory depth saturate.
    always_comb begin
        if (r_word_count == '0) begin
            eff_words = t_wcnt'(1);
        end else if ({{(IDX_IN_W + 1 - WCNT_W){1'b0}}, r_word_count} > WORDS_X) begin
            eff_words = WCNT_W'(WORDS);
        end else begin
            eff_words = r_word_count;
        end
    end

    sfdf_mod u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (in_fire && sampled_now),
        .i_dividend (i_hash_low[IDX_IN_W-1:0]),
        .i_divisor  (eff_words),
        .o_done     (mod_done),
        .o_rem      (mod_rem)
    );

    assign rem_ext  = {{(IDX_IN_W - WCNT_W){1'b0}}, mod_rem};
    assign word_idx = rem_ext[IDX_W-1:0];

    // Only positions from the first mismatch onward are rewritten. Before that
    // point nothing has been written, so every mismatch test sees the word as read.
    always_comb begin
        seen     = 1'b0;
        set_mask = '0;
        mism     = '0;
        active   = '0;
        for (int i = 0; i < MAX_POS; i++) begin
            if (HCNT_W'(i) < r_npos) begin
                mism[i] = r_rd_data[r_hash_high[i*8 +: POS_W]] != r_status;
                seen    = seen || mism[i];
                active[i] = seen;
            end
            if (active[i]) begin
                set_mask = set_mask | (HASH_W'(1) << r_hash_high[i*8 +: POS_W]);
            end
        end
        item_repeat = (mism == '0);
        new_word    = r_status ? (r_rd_data | set_mask) : (r_rd_data & ~set_mask);
    end

    assign mem_we    = (r_state == ST_CLEAR) || (r_state == ST_MOD);
    assign mem_waddr = (r_state == ST_CLEAR) ? r_clr_addr : word_idx;
    assign mem_wdata = (r_state == ST_CLEAR) ? WORD_RESET : new_word;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_filter_mem[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= r_filter_mem[word_idx];
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_clr_addr == IDX_W'(WORDS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_fire) begin
                    n_state = sampled_now ? ST_DIV : ST_PUSH;
                end
            end
            ST_DIV: begin
                if (mod_done) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: n_state = ST_MOD;
            ST_MOD:  n_state = ST_PUSH;
            ST_PUSH: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (r_state == ST_PUSH && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold  <= THR_RESET;
            r_hash_count <= HCNT_RESET;
            r_word_count <= WCNT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_SAMPLE_THRESHOLD: r_threshold  <= i_cfg_data;
                REG_HASH_COUNT:       r_hash_count <= i_cfg_data[HCNT_W-1:0];
                REG_WORD_COUNT:       r_word_count <= i_cfg_data[WCNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Item payload registers.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_hash_high   <= i_hash_high;
            r_status      <= i_hash_low[STATUS_BIT];
            r_npos        <= npos_now;
            r_res_sampled <= sampled_now;
            r_res_repeat  <= 1'b0;
        end else if (r_state == ST_MOD) begin
            r_res_repeat  <= item_repeat;
        end
        if (r_state == ST_PUSH && out_free) begin
            r_out_sampled <= r_res_sampled;
            r_out_repeat  <= r_res_repeat;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_sampled          = r_out_sampled;
    assign o_already_recorded = r_out_sampled && r_out_repeat;
    assign o_forward          = r_out_sampled && !r_out_repeat;

    `SFDF_ASSERT(a_one_item, i_clk, i_rst_n, in_fire |=> !o_in_ready, "second item accepted while busy")
    `SFDF_ASSERT(a_rmw_order, i_clk, i_rst_n, (r_state == ST_MOD) |-> ($past(r_state) == ST_READ), "write back without a read")
    `SFDF_ASSERT(a_div_state, i_clk, i_rst_n, mod_done |-> (r_state == ST_DIV), "remainder finished outside the divide step")
    `SFDF_ASSERT(a_flags, i_clk, i_rst_n, o_out_valid |-> ((o_already_recorded ^ o_forward) == o_sampled), "result flags inconsistent")
    `SFDF_ASSERT_ALWAYS(a_clear_block, i_clk, (r_state == ST_CLEAR) |-> !o_in_ready, "item accepted during the memory sweep")

endmodule

// ----- design/sfdf_mod.sv -----
// Iterative remainder unit: 16-bit dividend modulo a 12-bit divisor.
module sfdf_mod (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [sfdf_pkg::IDX_IN_W-1:0] i_dividend,
    input  sfdf_pkg::t_wcnt          i_divisor,
    output logic                     o_done,
    output sfdf_pkg::t_wcnt          o_rem
);
    import sfdf_pkg::*;

    localparam int N_ITER = IDX_IN_W / MOD_STEP;
    localparam int ITER_W = (N_ITER > 1) ? $clog2(N_ITER) : 1;

    logic                r_busy;
    logic [ITER_W-1:0]   r_cnt;
    logic [IDX_IN_W-1:0] r_quo;
    t_wcnt               r_rem;
    logic [IDX_IN_W-1:0] n_quo;
    t_wcnt               n_rem;
    logic [WCNT_W:0]     trial;

    // Restoring remainder steps, one dividend bit each, MOD_STEP per cycle.
    always_comb begin
        n_rem = r_rem;
        n_quo = r_quo;
        trial = '0;
        for (int j = 0; j < MOD_STEP; j++) begin
            trial = {n_rem, n_quo[IDX_IN_W-1]};
            n_quo = {n_quo[IDX_IN_W-2:0], 1'b0};
            if (trial >= {1'b0, i_divisor}) begin
                trial = trial - {1'b0, i_divisor};
            end
            n_rem = trial[WCNT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == ITER_W'(N_ITER - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
        end else if (r_busy) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    assign o_done = r_busy && (r_cnt == ITER_W'(N_ITER - 1));
    assign o_rem  = r_rem;

endmodule

// ----- tb/sv/sfdf_dedup_checker.sv -----
`timescale 1ns / 1ps
// Checker for the sampled flow duplicate filter: mirrors the filter words and checks each result beat.
module sfdf_dedup_checker #(
    parameter int WORDS = sfdf_pkg::WORDS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           i_in_ready,
    input  logic [sfdf_pkg::HASH_W-1:0]    i_hash_low,
    input  logic [sfdf_pkg::HASH_W-1:0]    i_hash_high,
    input  logic                           i_out_valid,
    input  logic                           i_out_ready,
    input  logic                           i_sampled,
    input  logic                           i_already_recorded,
    input  logic                           i_forward,
    input  logic                           i_cfg_we,
    input  logic [sfdf_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [sfdf_pkg::THR_W-1:0]     i_cfg_data,
    output int                             o_mismatches,
    output int                             o_pending
);
    import sfdf_pkg::*;

    typedef struct packed {
        logic sampled;
        logic already_recorded;
        logic forward;
    } t_dedup_flags;

    logic [HASH_W-1:0] filter_words [WORDS];
    logic [THR_W-1:0]  threshold;
    logic [HCNT_W-1:0] hash_count;
    t_wcnt             word_count;
    t_dedup_flags      expected_flags [$];
    int                mismatches = 0;

    // Tests the selected word against the status bit and marks it; returns the flags.
    function automatic t_dedup_flags lookup_and_mark(input logic [HASH_W-1:0] lo,
                                                     input logic [HASH_W-1:0] hi);
        t_dedup_flags      flags;
        int                n_words;
        int                n_pos;
        int                idx;
        int                i;
        logic [HASH_W-1:0] word;
        logic [POS_W-1:0]  pos;
        logic              status;
        logic              matched;
        flags = '0;
        if (lo[HASH_W-1:SAMPLE_LSB] < threshold) begin
            n_words = int'(word_count);
            if (n_words == 0)
                n_words = 1;
            if (n_words > WORDS)
                n_words = WORDS;
            n_pos = (int'(hash_count) > MAX_POS) ? MAX_POS : int'(hash_count);
            idx = int'(lo[IDX_IN_W-1:0]) % n_words;
            word = filter_words[idx];
            status = lo[STATUS_BIT];
            matched = 1'b1;
            // Once one position differs, it and every later one take the status value.
            for (i = 0; i < n_pos; i++) begin
                pos = hi[i*8 +: POS_W];
                if (matched && word[pos] != status)
                    matched = 1'b0;
                if (!matched)
                    word[pos] = status;
            end
            filter_words[idx] = word;
            flags.sampled = 1'b1;
            flags.already_recorded = matched;
            flags.forward = !matched;
        end
        return flags;
    endfunction

    always @(posedge i_clk) begin : monitor
        t_dedup_flags got;
        t_dedup_flags want;
        if (!i_rst_n) begin
            foreach (filter_words[k])
                filter_words[k] = WORD_RESET;
            threshold = THR_RESET;
            hash_count = HCNT_RESET;
            word_count = WCNT_RESET;
            expected_flags.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_SAMPLE_THRESHOLD: threshold = i_cfg_data;
                    REG_HASH_COUNT:       hash_count = i_cfg_data[HCNT_W-1:0];
                    REG_WORD_COUNT:       word_count = i_cfg_data[WCNT_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready)
                expected_flags.insert(expected_flags.size(),
                                      lookup_and_mark(i_hash_low, i_hash_high));
            if (i_out_valid && i_out_ready) begin
                got = {i_sampled, i_already_recorded, i_forward};
                if (expected_flags.size() == 0) begin
                    if (mismatches < 10)
                        $display("%0t: result beat with no item pending: %s%0b %s%0b %s%0b",
                                 $time, "sampled=", got.sampled,
                                 "rec=", got.already_recorded, "fwd=", got.forward);
                    mismatches++;
                end else begin
                    want = expected_flags.pop_front();
                    if (got !== want) begin
                        if (mismatches < 10)
                            $display("%0t: flag mismatch: expected %s%0b %s%0b %s%0b, %s",
                                     $time, "sampled=", want.sampled,
                                     "rec=", want.already_recorded,
                                     "fwd=", want.forward,
                                     $sformatf("got sampled=%0b rec=%0b fwd=%0b",
                                               got.sampled, got.already_recorded,
                                               got.forward));
                        mismatches++;
                    end
                end
            end
        end
        o_mismatches <= mismatches;
        o_pending <= expected_flags.size();
    end

endmodule

// ----- tb/sv/tb_sampled_flow_dedup_filter.sv -----
`timescale 1ns / 1ps
// Top of the sampled flow duplicate filter testbench: clock, reset, stimulus and verdict.
module tb_sampled_flow_dedup_filter;
    import sfdf_pkg::*;

    // Index past the register list; writes to it must be dropped.
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam logic [THR_W-1:0]     THR_MAX = '1;
    localparam int IDLE_LIMIT    = 20000;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS   = 100;
    localparam int KEY_POOL      = 16;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 out_ready = 1'b0;
    logic [HASH_W-1:0]    hash_low = '0;
    logic [HASH_W-1:0]    hash_high = '0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [THR_W-1:0]     cfg_data = '0;
    wire                  in_ready;
    wire                  out_valid;
    wire                  sampled;
    wire                  already_recorded;
    wire                  forward;
    int                   mismatches;
    int                   pending;

    logic [THR_W-1:0]  thr_now = THR_RESET;
    bit                send_steady = 1'b0;
    bit                recv_steady = 1'b0;
    int                stall_left = 0;
    logic [HASH_W-1:0] pool_low [KEY_POOL];
    logic [HASH_W-1:0] pool_high [KEY_POOL];

    always #5 clk = ~clk;

    sampled_flow_dedup_filter dut (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_in_valid         (in_valid),
        .o_in_ready         (in_ready),
        .i_hash_low         (hash_low),
        .i_hash_high        (hash_high),
        .o_out_valid        (out_valid),
        .i_out_ready        (out_ready),
        .o_sampled          (sampled),
        .o_already_recorded (already_recorded),
        .o_forward          (forward),
        .i_cfg_we           (cfg_we),
        .i_cfg_index        (cfg_index),
        .i_cfg_data         (cfg_data)
    );

    sfdf_dedup_checker flags_check (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_in_valid         (in_valid),
        .i_in_ready         (in_ready),
        .i_hash_low         (hash_low),
        .i_hash_high        (hash_high),
        .i_out_valid        (out_valid),
        .i_out_ready        (out_ready),
        .i_sampled          (sampled),
        .i_already_recorded (already_recorded),
        .i_forward          (forward),
        .i_cfg_we           (cfg_we),
        .i_cfg_index        (cfg_index),
        .i_cfg_data         (cfg_data),
        .o_mismatches       (mismatches),
        .o_pending          (pending)
    );

    // Mostly short pauses, now and then a long one.
    function automatic int pause_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // A key whose top bits fall below the current threshold, or a random key when the threshold is zero.
    function automatic logic [HASH_W-1:0] sampled_low();
        logic [31:0] top;
        top = (thr_now == 0) ? $urandom : $urandom_range(32'(thr_now) - 1, 0);
        return {top[THR_W-1:0], 1'($urandom), 32'($urandom)};
    endfunction

    always @(negedge clk) begin
        if (stall_left == 0 && !recv_steady && $urandom_range(0, 3) == 0)
            stall_left = pause_len();
        if (stall_left > 0) begin
            out_ready <= 1'b0;
            stall_left--;
        end else begin
            out_ready <= 1'b1;
        end
    end

    // Returns at the rising edge where the beat is taken; valid is still high then.
    task automatic send_hash(input logic [HASH_W-1:0] lo, input logic [HASH_W-1:0] hi);
        int gap;
        gap = send_steady ? 0 : pause_len();
        @(negedge clk);
        if (gap > 0) begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        hash_low = lo;
        hash_high = hi;
        in_valid = 1'b1;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic settle();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    // Upper data bits carry noise on the narrow registers; the block must mask them.
    task automatic set_config(input logic [THR_W-1:0] thr, input logic [HCNT_W-1:0] hc,
                              input t_wcnt wc, input bit poke_unused);
        settle();
        cfg_we = 1'b1;
        cfg_index = REG_SAMPLE_THRESHOLD;
        cfg_data = thr;
        @(negedge clk);
        cfg_index = REG_HASH_COUNT;
        cfg_data = THR_W'($urandom);
        cfg_data[HCNT_W-1:0] = hc;
        @(negedge clk);
        cfg_index = REG_WORD_COUNT;
        cfg_data = THR_W'($urandom);
        cfg_data[WCNT_W-1:0] = wc;
        @(negedge clk);
        if (poke_unused) begin
            cfg_index = REG_UNUSED;
            cfg_data = THR_W'($urandom);
            @(negedge clk);
        end
        cfg_we = 1'b0;
        thr_now = thr;
    endtask

    initial begin : watchdog
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT) begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle = 0;
            else
                idle++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    initial begin : stimulus
        logic [HASH_W-1:0] lo;
        logic [HASH_W-1:0] hi;
        logic [THR_W-1:0]  thr;
        logic [HCNT_W-1:0] hc;
        t_wcnt             wc;
        int                slot;
        int                r;
        int                p;
        int                i;

        repeat (7) @(negedge clk);
        rst_n = 1'b1;

        // Reset settings: not sampled, status zero and one on a fresh word, threshold edge.
        send_hash('1, '1);
        send_hash('0, '0);
        send_hash({31'd0, 1'b1, 32'd0}, '0);
        send_hash({31'd0, 1'b1, 32'd0}, '0);
        lo = {THR_RESET - 31'd1, 1'b1, 16'h1234, 16'hffff};
        send_hash(lo, 64'hC0C1C2C3_FFFEFDFC);
        send_hash({THR_RESET, 1'b1, 16'h1234, 16'hffff}, 64'hC0C1C2C3_FFFEFDFC);
        send_hash(lo, 64'hC0C1C2C3_FFFEFDFC);

        // No positions tested and word count zero; the widest threshold.
        set_config(THR_MAX, 4'd0, 12'd0, 1'b0);
        send_hash({THR_MAX - 31'd1, 1'b1, 32'($urandom)}, {$urandom, $urandom});
        send_hash('1, '0);
        send_hash('0, '1);

        // Both counts above their limits, plus a write that must be ignored.
        set_config(THR_MAX, 4'd15, 12'hfff, 1'b1);
        send_hash({31'd5, 1'b1, 16'h0, 16'hffff}, 64'h3F3E3D3C_3B3A3938);
        send_hash({31'd5, 1'b1, 16'h0, 16'hffff}, 64'h3F3E3D3C_3B3A3938);
        send_hash({31'd7, 1'b0, 16'h0, 16'hffff}, '1);
        send_hash({31'd9, 1'b0, 32'd0}, 64'h01010101_01010101);

        // Zero threshold passes nothing.
        set_config(31'd0, 4'd8, 12'd1, 1'b0);
        send_hash('0, {$urandom, $urandom});
        send_hash('1, {$urandom, $urandom});

        // One word in use: every sampled item lands on the same word.
        set_config(31'd1, 4'd8, 12'd1, 1'b0);
        hi = {$urandom, $urandom};
        send_hash({31'd0, 1'b1, 32'($urandom)}, hi);
        send_hash({31'd0, 1'b1, 32'($urandom)}, hi);
        send_hash({31'd0, 1'b0, 32'($urandom)}, {$urandom, $urandom});

        for (p = 0; p < RANDOM_PHASES; p++) begin
            case ($urandom_range(0, 3))
                0: thr = THR_MAX;
                1: thr = THR_W'($urandom);
                2: thr = THR_W'($urandom_range(1, 64));
                default: thr = THR_RESET;
            endcase
            hc = ($urandom_range(0, 3) == 0) ? HCNT_W'($urandom_range(0, 15))
                                             : HCNT_W'($urandom_range(1, 8));
            case ($urandom_range(0, 3))
                0: wc = t_wcnt'($urandom_range(1, 8));
                1: wc = t_wcnt'($urandom);
                2: wc = t_wcnt'(WORDS_DEF);
                default: wc = t_wcnt'($urandom_range(1, 64));
            endcase
            set_config(thr, hc, wc, 1'($urandom));
            send_steady = ($urandom_range(0, 3) == 0);
            recv_steady = ($urandom_range(0, 3) == 0);
            for (i = 0; i < KEY_POOL; i++) begin
                pool_low[i] = sampled_low();
                pool_high[i] = {$urandom, $urandom};
            end
            // Keys recur from a small pool so that repeats show up; some beats are noise.
            for (i = 0; i < PHASE_ITEMS; i++) begin
                r = $urandom_range(0, 99);
                slot = $urandom_range(0, KEY_POOL - 1);
                if (r < 50) begin
                    lo = pool_low[slot];
                    hi = pool_high[slot];
                end else if (r < 85) begin
                    lo = sampled_low();
                    hi = {$urandom, $urandom};
                    pool_low[slot] = lo;
                    pool_high[slot] = hi;
                end else begin
                    lo = {$urandom, $urandom};
                    hi = {$urandom, $urandom};
                end
                send_hash(lo, hi);
            end
        end

        send_steady = 1'b0;
        recv_steady = 1'b0;
        settle();
        repeat (20) @(negedge clk);
        if (mismatches == 0 && pending == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+design
design/sfdf_pkg.sv
design/sfdf_mod.sv
design/sampled_flow_dedup_filter.sv
tb/sv/sfdf_dedup_checker.sv
tb/sv/tb_sampled_flow_dedup_filter.sv
